/* src/rgbv210_pkg.sv */
package rgbv210_pkg;

    // Component and port geometry
    localparam int COMP_W     = 10;
    localparam int WORD_W     = 30;
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 21;
    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_COEF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA1_COEF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA2_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_BIT  = 3'd3;

    // Matrix offsets in 2^20 fixed point
    localparam logic [31:0] LUMA_OFFSET   = 32'd64 << 20;
    localparam logic [31:0] CHROMA_OFFSET = 32'd1025 << 19;

    // Components of a black pixel after the matrix
    localparam logic [COMP_W-1:0] BLACK_LUMA   = 10'd64;
    localparam logic [COMP_W-1:0] BLACK_CHROMA = 10'd512;

    // Pixel position inside a six-pixel group
    typedef enum logic [5:0] {
        PH0 = 6'b000001,
        PH1 = 6'b000010,
        PH2 = 6'b000100,
        PH3 = 6'b001000,
        PH4 = 6'b010000,
        PH5 = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              run_last;
        logic              row_last;
    } out_item_t;

endpackage

/* src/rgb_to_v210_packer_core.sv */
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-------------------------------------
// in       | input     | in_valid / in_ready   | in_data  (red, green, blue, row_end)
// out      | output    | out_valid / out_ready | out_data (packed_word, run_last, row_last)
// cfg      | input     | cfg_write_en          | cfg_index, cfg_data
//
// One pixel per cycle is accepted and processed while the output is not stalled and
// no padding runs; pixels pass the pixel register, then the word register. A row end
// at group position p (0..5) adds 5-p black pixels through the same matrix/packing
// stage, one per cycle while the output is not stalled. Reset clears control state,
// coefficients and the mode bit. A stalled output holds the word register; the pixel
// register still takes a new pixel once its current pixel has moved on.
module rgb_to_v210_packer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rgbv210_pkg::in_item_t               in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rgbv210_pkg::out_item_t              out_data,
    input  logic                                cfg_write_en,
    input  logic [rgbv210_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbv210_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = rgbv210_pkg::COMP_W;

    // One matrix row: signed coefficients times 10-bit components, mod 2^32
    function automatic logic [CW-1:0] matrix_row(
        input logic [rgbv210_pkg::CFG_DATA_W-1:0] coefs,
        input logic [31:0]                        offset,
        input logic [CW-1:0]                      r,
        input logic [CW-1:0]                      g,
        input logic [CW-1:0]                      b
    );
        logic signed [31:0] kr, kg, kb;
        logic signed [31:0] xr, xg, xb;
        logic [31:0]        acc;
        kr  = {{11{coefs[20]}}, coefs[20:0]};
        kg  = {{11{coefs[41]}}, coefs[41:21]};
        kb  = {{11{coefs[62]}}, coefs[62:42]};
        xr  = {22'd0, r};
        xg  = {22'd0, g};
        xb  = {22'd0, b};
        acc = offset + 32'(kr * xr) + 32'(kg * xg) + 32'(kb * xb);
        return acc[29:20];
    endfunction

    // Configuration registers
    logic [rgbv210_pkg::CFG_DATA_W-1:0] luma_coef_reg;
    logic [rgbv210_pkg::CFG_DATA_W-1:0] chroma1_coef_reg;
    logic [rgbv210_pkg::CFG_DATA_W-1:0] chroma2_coef_reg;
    logic                               sixteen_bit_reg;

    // Pipeline state
    rgbv210_pkg::in_item_t  pix_reg;
    logic                   pix_valid_reg, pix_valid_next;
    rgbv210_pkg::phase_t    phase_reg, phase_next;
    logic                   pad_reg, pad_next;
    logic [2*CW-1:0]        pend_reg, pend_next;
    rgbv210_pkg::out_item_t out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic            out_free, step_pix, step_pad, step, row_ctx;
    logic [CW-1:0]   r10, g10, b10;
    logic [CW-1:0]   comp_y, comp_c1, comp_c2;
    logic            emit;
    logic [rgbv210_pkg::WORD_W-1:0] word;
    logic [2*CW-1:0] pend_new;
    rgbv210_pkg::phase_t phase_inc;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_coef_reg    <= '0;
            chroma1_coef_reg <= '0;
            chroma2_coef_reg <= '0;
            sixteen_bit_reg  <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                rgbv210_pkg::REG_LUMA_COEF:    luma_coef_reg    <= cfg_data;
                rgbv210_pkg::REG_CHROMA1_COEF: chroma1_coef_reg <= cfg_data;
                rgbv210_pkg::REG_CHROMA2_COEF: chroma2_coef_reg <= cfg_data;
                rgbv210_pkg::REG_SIXTEEN_BIT:  sixteen_bit_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: padding pixels go before the waiting real pixel
    assign out_free = !out_valid_reg || out_ready;
    assign step_pad = pad_reg && out_free;
    assign step_pix = pix_valid_reg && !pad_reg && out_free;
    assign step     = step_pad || step_pix;
    assign in_ready = !pix_valid_reg || step_pix;
    assign row_ctx  = pad_reg || pix_reg.row_end;

    // Bring components to 10 bits
    assign r10 = sixteen_bit_reg ? pix_reg.red[15:6]   : {pix_reg.red[7:0], 2'b00};
    assign g10 = sixteen_bit_reg ? pix_reg.green[15:6] : {pix_reg.green[7:0], 2'b00};
    assign b10 = sixteen_bit_reg ? pix_reg.blue[15:6]  : {pix_reg.blue[7:0], 2'b00};

    // Color matrix, or fixed black values while padding
    assign comp_y  = pad_reg ? rgbv210_pkg::BLACK_LUMA
                   : matrix_row(luma_coef_reg, rgbv210_pkg::LUMA_OFFSET, r10, g10, b10);
    assign comp_c1 = pad_reg ? rgbv210_pkg::BLACK_CHROMA
                   : matrix_row(chroma1_coef_reg, rgbv210_pkg::CHROMA_OFFSET, r10, g10, b10);
    assign comp_c2 = pad_reg ? rgbv210_pkg::BLACK_CHROMA
                   : matrix_row(chroma2_coef_reg, rgbv210_pkg::CHROMA_OFFSET, r10, g10, b10);

    // Packing per group position; pending fill is fixed by the position
    always_comb
    begin
        emit      = 1'b0;
        word      = {comp_c2, comp_y, comp_c1};
        pend_new  = '0;
        phase_inc = rgbv210_pkg::PH0;
        case (phase_reg)
            rgbv210_pkg::PH0:
            begin
                emit      = 1'b1;
                phase_inc = rgbv210_pkg::PH1;
            end
            rgbv210_pkg::PH1:
            begin
                pend_new  = {{CW{1'b0}}, comp_y};
                phase_inc = rgbv210_pkg::PH2;
            end
            rgbv210_pkg::PH2:
            begin
                emit      = 1'b1;
                word      = {comp_y, comp_c1, pend_reg[CW-1:0]};
                pend_new  = {{CW{1'b0}}, comp_c2};
                phase_inc = rgbv210_pkg::PH3;
            end
            rgbv210_pkg::PH3:
            begin
                pend_new  = {comp_y, pend_reg[CW-1:0]};
                phase_inc = rgbv210_pkg::PH4;
            end
            rgbv210_pkg::PH4:
            begin
                emit      = 1'b1;
                word      = {comp_c1, pend_reg};
                pend_new  = {comp_c2, comp_y};
                phase_inc = rgbv210_pkg::PH5;
            end
            rgbv210_pkg::PH5:
            begin
                emit      = 1'b1;
                word      = {comp_y, pend_reg};
                phase_inc = rgbv210_pkg::PH0;
            end
            default: ;
        endcase
    end

    // Next-state logic
    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        phase_next     = phase_reg;
        pad_next       = pad_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (step_pix)
            pix_valid_next = 1'b0;
        if (in_valid && in_ready)
            pix_valid_next = 1'b1;

        if (step)
        begin
            phase_next = phase_inc;
            pend_next  = pend_new;
            pad_next   = row_ctx && (phase_reg != rgbv210_pkg::PH5);
            if (emit)
            begin
                out_valid_next       = 1'b1;
                out_next.packed_word = word;
                out_next.run_last    = !row_ctx || (phase_reg == rgbv210_pkg::PH5);
                out_next.row_last    = row_ctx && (phase_reg == rgbv210_pkg::PH5);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            phase_reg     <= rgbv210_pkg::PH0;
            pad_reg       <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            phase_reg     <= phase_next;
            pad_reg       <= pad_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pix_reg <= in_data;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Padding only runs in the middle of a group
    a_pad_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg |-> phase_reg != rgbv210_pkg::PH0)
        else $error("padding active at group start");

    // End of row always closes the group
    a_row_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit && row_ctx && phase_reg == rgbv210_pkg::PH5)
        |=> (phase_reg == rgbv210_pkg::PH0) && !pad_reg)
        else $error("row end did not return to group start");

    // Padding starts only from a pixel marked as row end
    a_pad_from_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pad_reg) |-> $past(step_pix && pix_reg.row_end))
        else $error("padding started without row end");

    // A row-final word is also the last word of its transaction
    a_row_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.row_last) |-> out_reg.run_last)
        else $error("row_last without run_last");

endmodule
